FILE: sv/fat_cluster_chain_table_defines.svh
// assertion macros for the cluster table datapath rtl
`ifndef FAT_CLUSTER_CHAIN_TABLE_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_TABLE_DEFINES_SVH

// clocked check on i_clk, off while i_rst_n is low
`define FCCT_ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fcct assertion failed");

// same-cycle implication built on the macro above
`define FCCT_ASSERT_IMPLIES(label, pre, post) \
    `FCCT_ASSERT_CLK(label, (pre) |-> (post))

`endif

FILE: sv/fcct_pkg.sv
// types, constants and codes of the cluster table
`default_nettype none
package fcct_pkg;

    localparam int TABLE_ENTRIES = 16384;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W         = 17;

    localparam logic [15:0] END_OF_CHAIN       = 16'hFFF8;
    localparam logic [15:0] ENTRY0_RESET       = 16'hFFF8;
    localparam logic [15:0] ENTRY1_RESET       = 16'hFFFF;
    localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;

    localparam logic [14:0] ENTRIES_RESET    = 15'd16384;
    localparam logic [31:0] DATA_START_RESET = 32'd161;
    localparam logic [7:0]  SPC_RESET        = 8'd1;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_NEXT  = 2'd1,
        ACT_LINK  = 2'd2,
        ACT_FREE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_LIMIT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_ENTRIES    = 2'd0,
        REG_DATA_START = 2'd1,
        REG_SPC        = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NEXT_DATA,
        S_FREE_CHK,
        S_FREE_WR,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_TWO,
        ADDR_INC,
        ADDR_DATA
    } t_addr_op;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_EOC,
        WD_VAL
    } t_wdata_sel;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_CL,
        RES_ADDR,
        RES_ZERO,
        RES_DATA
    } t_res_op;

    typedef struct packed {
        logic [31:0]      data_start;
        logic [7:0]       spc;
        logic [CNT_W-1:0] live;
    } t_cfg;

    typedef struct packed {
        logic       ld_in;
        logic       clr_step;
        t_addr_op   addr_op;
        logic       rd;
        logic       wr;
        t_wdata_sel wsel;
        t_res_op    res_op;
        t_status    res_st;
        logic       steps_inc;
        logic       mul;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic    clr_last;
        t_action act;
        logic    in_chain;
        logic    addr_lt_n;
        logic    steps_ge_n;
        logic    rdata_zero;
        logic    out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: sv/fat_cluster_chain_table.sv
// top level of the fat16 cluster chain table
// ---------------------------------------------------------------------------
// requests arrive on the s_axis channel, one word per request: tuser holds
// the action (allocate, next, link, free chain), tdata the cluster and the
// link value. each request yields exactly one word on m_axis with the result
// cluster, its first data sector, an end-of-chain flag and a status code.
// the three configuration registers sit behind an apb port (pready always
// high); the user must see that they are written only while no request is
// in flight, the block itself does not enforce it. the table is one single
// port ram of 16-bit entries with registered read; requests are served one
// at a time. link writes its entry at decode; next reads the entry (range
// status outside the table); allocate reads and checks each entry from
// cluster 2 in turn; free chain reads and clears each entry of the chain;
// every request then passes the multiply and done states. after reset a
// clearing pass writes all 16384 entries, one per cycle (entry 0 and 1 get
// their reserved marks); s_axis_tready stays low for the whole pass, apb
// writes are taken as usual. the result waits in an output register; while
// m_axis stalls the next request is still accepted and worked, and its
// result holds until the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none
module fat_cluster_chain_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] cluster, [31:16] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    // result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [15:0] result_cluster, [47:16] first_sector
    output logic [2:0]       m_axis_tuser,   // [0] end_of_chain, [2:1] status
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    fcct_pkg::t_cfg cfg;
    fcct_pkg::t_cmd cmd;
    fcct_pkg::t_sts sts;

    logic [15:0] result_cluster;
    logic [31:0] first_sector;
    logic        end_of_chain;
    logic [1:0]  status;

    // register file, clamps the entry count to the table size
    fcct_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: clearing pass, request decode, scan and walk steps
    fcct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table ram, walk registers, sector arithmetic, result register
    fcct_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg            (cfg),
        .i_action         (s_axis_tuser),
        .i_cluster        (s_axis_tdata[15:0]),
        .i_value          (s_axis_tdata[31:16]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_result_cluster (result_cluster),
        .o_first_sector   (first_sector),
        .o_end_of_chain   (end_of_chain),
        .o_status         (status)
    );

    assign m_axis_tdata = {first_sector, result_cluster};
    assign m_axis_tuser = {status, end_of_chain};

endmodule
`default_nettype wire

FILE: sv/fcct_regs.sv
// apb configuration registers and live entry count
`default_nettype none
module fcct_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output fcct_pkg::t_cfg    o_cfg
);

    logic [14:0] r_entries;
    logic [31:0] r_data_start;
    logic [7:0]  r_spc;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries    <= fcct_pkg::ENTRIES_RESET;
            r_data_start <= fcct_pkg::DATA_START_RESET;
            r_spc        <= fcct_pkg::SPC_RESET;
        end else if (wr_en) begin
            case (fcct_pkg::t_reg_idx'(paddr[3:2]))
                fcct_pkg::REG_ENTRIES:    r_entries    <= pwdata[14:0];
                fcct_pkg::REG_DATA_START: r_data_start <= pwdata;
                fcct_pkg::REG_SPC:        r_spc        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (fcct_pkg::t_reg_idx'(paddr[3:2]))
            fcct_pkg::REG_ENTRIES:    prdata = {17'd0, r_entries};
            fcct_pkg::REG_DATA_START: prdata = r_data_start;
            fcct_pkg::REG_SPC:        prdata = {24'd0, r_spc};
            default:                  prdata = 32'd0;
        endcase
    end

    // effective count is clamped to the physical table
    always_comb begin
        o_cfg.data_start = r_data_start;
        o_cfg.spc        = r_spc;
        if (fcct_pkg::CMP_W'(r_entries) > fcct_pkg::CMP_W'(fcct_pkg::TABLE_ENTRIES)) begin
            o_cfg.live = fcct_pkg::CNT_W'(fcct_pkg::TABLE_ENTRIES);
        end else begin
            o_cfg.live = fcct_pkg::CNT_W'(r_entries);
        end
    end

endmodule
`default_nettype wire

FILE: sv/fcct_ctrl.sv
// request sequencer for the cluster table
`default_nettype none
module fcct_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire fcct_pkg::t_sts i_sts,
    output fcct_pkg::t_cmd      o_cmd
);

    fcct_pkg::t_state r_state;
    fcct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcct_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fcct_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = fcct_pkg::S_IDLE;
            end
            fcct_pkg::S_IDLE: begin
                if (i_in_valid) n_state = fcct_pkg::S_DECODE;
            end
            fcct_pkg::S_DECODE: begin
                unique case (i_sts.act)
                    fcct_pkg::ACT_ALLOC: n_state = fcct_pkg::S_SCAN_RD;
                    fcct_pkg::ACT_NEXT: begin
                        n_state = i_sts.addr_lt_n ? fcct_pkg::S_NEXT_DATA : fcct_pkg::S_MUL;
                    end
                    fcct_pkg::ACT_LINK:  n_state = fcct_pkg::S_MUL;
                    fcct_pkg::ACT_FREE:  n_state = fcct_pkg::S_FREE_CHK;
                endcase
            end
            fcct_pkg::S_SCAN_RD: begin
                n_state = i_sts.addr_lt_n ? fcct_pkg::S_SCAN_CHK : fcct_pkg::S_MUL;
            end
            fcct_pkg::S_SCAN_CHK: begin
                n_state = i_sts.rdata_zero ? fcct_pkg::S_MUL : fcct_pkg::S_SCAN_RD;
            end
            fcct_pkg::S_NEXT_DATA: n_state = fcct_pkg::S_MUL;
            fcct_pkg::S_FREE_CHK: begin
                if (i_sts.in_chain && i_sts.addr_lt_n && !i_sts.steps_ge_n) begin
                    n_state = fcct_pkg::S_FREE_WR;
                end else begin
                    n_state = fcct_pkg::S_MUL;
                end
            end
            fcct_pkg::S_FREE_WR: n_state = fcct_pkg::S_FREE_CHK;
            fcct_pkg::S_MUL:     n_state = fcct_pkg::S_DONE;
            fcct_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = fcct_pkg::S_IDLE;
            end
            default: n_state = fcct_pkg::S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.ld_in     = 1'b0;
        o_cmd.clr_step  = 1'b0;
        o_cmd.addr_op   = fcct_pkg::ADDR_HOLD;
        o_cmd.rd        = 1'b0;
        o_cmd.wr        = 1'b0;
        o_cmd.wsel      = fcct_pkg::WD_ZERO;
        o_cmd.res_op    = fcct_pkg::RES_HOLD;
        o_cmd.res_st    = fcct_pkg::ST_OK;
        o_cmd.steps_inc = 1'b0;
        o_cmd.mul       = 1'b0;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            fcct_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            fcct_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.ld_in = i_in_valid;
            end
            fcct_pkg::S_DECODE: begin
                unique case (i_sts.act)
                    fcct_pkg::ACT_ALLOC: o_cmd.addr_op = fcct_pkg::ADDR_TWO;
                    fcct_pkg::ACT_NEXT: begin
                        if (i_sts.addr_lt_n) begin
                            o_cmd.rd = 1'b1;
                        end else begin
                            o_cmd.res_op = fcct_pkg::RES_CL;
                            o_cmd.res_st = fcct_pkg::ST_RANGE;
                        end
                    end
                    fcct_pkg::ACT_LINK: begin
                        o_cmd.res_op = fcct_pkg::RES_CL;
                        if (i_sts.addr_lt_n) begin
                            o_cmd.wr   = 1'b1;
                            o_cmd.wsel = fcct_pkg::WD_VAL;
                        end else begin
                            o_cmd.res_st = fcct_pkg::ST_RANGE;
                        end
                    end
                    fcct_pkg::ACT_FREE: ;
                endcase
            end
            fcct_pkg::S_SCAN_RD: begin
                if (i_sts.addr_lt_n) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    o_cmd.res_op = fcct_pkg::RES_ZERO;
                    o_cmd.res_st = fcct_pkg::ST_FULL;
                end
            end
            fcct_pkg::S_SCAN_CHK: begin
                if (i_sts.rdata_zero) begin
                    o_cmd.wr     = 1'b1;
                    o_cmd.wsel   = fcct_pkg::WD_EOC;
                    o_cmd.res_op = fcct_pkg::RES_ADDR;
                end else begin
                    o_cmd.addr_op = fcct_pkg::ADDR_INC;
                end
            end
            fcct_pkg::S_NEXT_DATA: o_cmd.res_op = fcct_pkg::RES_DATA;
            fcct_pkg::S_FREE_CHK: begin
                priority if (!i_sts.in_chain) begin
                    o_cmd.res_op = fcct_pkg::RES_CL;
                end else if (!i_sts.addr_lt_n) begin
                    o_cmd.res_op = fcct_pkg::RES_CL;
                    o_cmd.res_st = fcct_pkg::ST_RANGE;
                end else if (i_sts.steps_ge_n) begin
                    o_cmd.res_op = fcct_pkg::RES_CL;
                    o_cmd.res_st = fcct_pkg::ST_LIMIT;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            fcct_pkg::S_FREE_WR: begin
                o_cmd.wr        = 1'b1;
                o_cmd.wsel      = fcct_pkg::WD_ZERO;
                o_cmd.addr_op   = fcct_pkg::ADDR_DATA;
                o_cmd.steps_inc = 1'b1;
            end
            fcct_pkg::S_MUL:  o_cmd.mul = 1'b1;
            fcct_pkg::S_DONE: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/fcct_dp.sv
// cluster table memory, walk registers, sector math and result register
`default_nettype none
`include "fat_cluster_chain_table_defines.svh"
module fcct_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire fcct_pkg::t_cmd i_cmd,
    output fcct_pkg::t_sts      o_sts,
    input  wire fcct_pkg::t_cfg i_cfg,
    input  wire logic [1:0]     i_action,
    input  wire logic [15:0]    i_cluster,
    input  wire logic [15:0]    i_value,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [15:0]         o_result_cluster,
    output logic [31:0]         o_first_sector,
    output logic                o_end_of_chain,
    output logic [1:0]          o_status
);

    logic [15:0] r_mem [fcct_pkg::TABLE_ENTRIES];

    logic [fcct_pkg::IDX_W-1:0] r_clr_addr;
    logic [15:0]                clr_data;
    logic [15:0]                wdata;

    fcct_pkg::t_action          r_act;
    logic [15:0]                r_cl;
    logic [15:0]                r_val;
    logic [15:0]                r_addr;
    logic [fcct_pkg::CNT_W-1:0] r_steps;
    logic [15:0]                r_rdata;
    logic [15:0]                r_rc;
    fcct_pkg::t_status          r_st;
    logic [31:0]                r_prod;

    logic                       r_out_valid;
    logic [15:0]                r_out_rc;
    logic [31:0]                r_out_sector;
    logic                       r_out_eoc;
    logic [1:0]                 r_out_st;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + fcct_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        if (r_clr_addr == fcct_pkg::IDX_W'(0)) begin
            clr_data = fcct_pkg::ENTRY0_RESET;
        end else if (r_clr_addr == fcct_pkg::IDX_W'(1)) begin
            clr_data = fcct_pkg::ENTRY1_RESET;
        end else begin
            clr_data = 16'd0;
        end
    end

    always_comb begin
        unique case (i_cmd.wsel)
            fcct_pkg::WD_ZERO: wdata = 16'd0;
            fcct_pkg::WD_EOC:  wdata = fcct_pkg::END_OF_CHAIN;
            fcct_pkg::WD_VAL:  wdata = r_val;
            default:           wdata = 16'd0;
        endcase
    end

    // single port table, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= clr_data;
        end else if (i_cmd.wr) begin
            r_mem[r_addr[fcct_pkg::IDX_W-1:0]] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_addr[fcct_pkg::IDX_W-1:0]];
        end
    end

    // request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_act   <= fcct_pkg::t_action'(i_action);
            r_cl    <= i_cluster;
            r_val   <= i_value;
            r_steps <= '0;
        end else if (i_cmd.steps_inc) begin
            r_steps <= r_steps + fcct_pkg::CNT_W'(1);
        end

        if (i_cmd.ld_in) begin
            r_addr <= i_cluster;
        end else begin
            unique case (i_cmd.addr_op)
                fcct_pkg::ADDR_HOLD: r_addr <= r_addr;
                fcct_pkg::ADDR_TWO:  r_addr <= fcct_pkg::FIRST_DATA_CLUSTER;
                fcct_pkg::ADDR_INC:  r_addr <= r_addr + 16'd1;
                fcct_pkg::ADDR_DATA: r_addr <= r_rdata;
                default:             r_addr <= r_addr;
            endcase
        end

        unique case (i_cmd.res_op)
            fcct_pkg::RES_HOLD: ;
            fcct_pkg::RES_CL: begin
                r_rc <= r_cl;
                r_st <= i_cmd.res_st;
            end
            fcct_pkg::RES_ADDR: begin
                r_rc <= r_addr;
                r_st <= i_cmd.res_st;
            end
            fcct_pkg::RES_ZERO: begin
                r_rc <= 16'd0;
                r_st <= i_cmd.res_st;
            end
            fcct_pkg::RES_DATA: begin
                r_rc <= r_rdata;
                r_st <= i_cmd.res_st;
            end
            default: ;
        endcase

        // (cluster - 2) * sectors per cluster, wraps modulo 2^32
        if (i_cmd.mul) begin
            r_prod <= (32'(r_rc) - 32'(fcct_pkg::FIRST_DATA_CLUSTER)) * 32'(i_cfg.spc);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rc     <= r_rc;
            r_out_sector <= i_cfg.data_start + r_prod;
            r_out_eoc    <= (r_rc >= fcct_pkg::END_OF_CHAIN);
            r_out_st     <= r_st;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_cluster = r_out_rc;
    assign o_first_sector   = r_out_sector;
    assign o_end_of_chain   = r_out_eoc;
    assign o_status         = r_out_st;

    always_comb begin
        o_sts.clr_last   = (r_clr_addr == fcct_pkg::IDX_W'(fcct_pkg::TABLE_ENTRIES - 1));
        o_sts.act        = r_act;
        o_sts.in_chain   = (r_addr >= fcct_pkg::FIRST_DATA_CLUSTER)
                           && (r_addr < fcct_pkg::END_OF_CHAIN);
        o_sts.addr_lt_n  = fcct_pkg::CMP_W'(r_addr) < fcct_pkg::CMP_W'(i_cfg.live);
        o_sts.steps_ge_n = fcct_pkg::CMP_W'(r_steps) >= fcct_pkg::CMP_W'(i_cfg.live);
        o_sts.rdata_zero = (r_rdata == 16'd0);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // table accesses stay inside the addressable range
    `FCCT_ASSERT_IMPLIES(a_rd_in_table, i_cmd.rd, o_sts.addr_lt_n)
    `FCCT_ASSERT_IMPLIES(a_wr_in_table, i_cmd.wr, o_sts.addr_lt_n)
    // a new result never overwrites one still waiting
    `FCCT_ASSERT_IMPLIES(a_out_load_free, i_cmd.out_load, (!r_out_valid || i_out_ready))
    // a free-walk clear always follows the read of that entry
    `FCCT_ASSERT_CLK(a_clear_after_read, (i_cmd.steps_inc |-> $past(i_cmd.rd)))

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the fat16 cluster chain table: streamed requests vs a local table model
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEMS_TOTAL  = 1275;
    localparam int unsigned QUIET_LIMIT  = 150000;

    typedef struct packed {
        fcct_pkg::t_action act;
        logic [15:0]       cl;
        logic [15:0]       val;
    } t_request;

    typedef struct packed {
        logic [15:0]       cl;
        logic [31:0]       sector;
        logic              eoc;
        fcct_pkg::t_status st;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] cluster, [31:16] value
    logic [1:0]  s_axis_tuser = '0;   // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [47:0] m_axis_tdata;        // [15:0] result_cluster, [47:16] first_sector
    logic [2:0]  m_axis_tuser;        // [0] end_of_chain, [2:1] status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fat_cluster_chain_table DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // local copy of the table and the registers
    logic [15:0] fat_copy [0:fcct_pkg::TABLE_ENTRIES-1];
    logic [14:0] cfg_entries    = fcct_pkg::ENTRIES_RESET;
    logic [31:0] cfg_data_start = fcct_pkg::DATA_START_RESET;
    logic [7:0]  cfg_spc        = fcct_pkg::SPC_RESET;

    t_request    requests_pending [$];
    t_outcome    outcomes_due [$];
    int unsigned requests_made = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned req_wait = 0;
    int unsigned res_hold = 0;
    bit          req_fire = 1'b0;
    bit          res_fire = 1'b0;
    bit          calm_req = 1'b0;
    bit          calm_res = 1'b0;

    int unsigned entries_plan [0:11] = '{16, 40, 16384, 3, 24, 64, 32767, 16, 1, 100, 20, 48};

    function automatic int unsigned live_entries();
        return (cfg_entries > fcct_pkg::TABLE_ENTRIES) ? fcct_pkg::TABLE_ENTRIES
                                                       : int'(cfg_entries);
    endfunction

    // low part of the table where chains are built
    function automatic int unsigned window();
        return (live_entries() < 64) ? live_entries() : 64;
    endfunction

    function automatic int unsigned gap_draw(input bit calm);
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // applies one request to the local table and returns the word it must produce
    function automatic t_outcome apply_request(input fcct_pkg::t_action act,
                                               input logic [15:0] cl,
                                               input logic [15:0] val);
        t_outcome          o;
        int unsigned       n, c, nx, steps;
        logic [15:0]       rc;
        fcct_pkg::t_status st;
        bit                walking;
        n  = live_entries();
        rc = cl;
        st = fcct_pkg::ST_OK;
        case (act)
            fcct_pkg::ACT_ALLOC: begin
                rc = 16'd0;
                st = fcct_pkg::ST_FULL;
                for (c = 2; c < n && st == fcct_pkg::ST_FULL; c++) begin
                    if (fat_copy[c] == 16'd0) begin
                        fat_copy[c] = fcct_pkg::END_OF_CHAIN;
                        rc = 16'(c);
                        st = fcct_pkg::ST_OK;
                    end
                end
            end
            fcct_pkg::ACT_NEXT: begin
                if (cl < n) rc = fat_copy[cl];
                else st = fcct_pkg::ST_RANGE;
            end
            fcct_pkg::ACT_LINK: begin
                if (cl < n) fat_copy[cl] = val;
                else st = fcct_pkg::ST_RANGE;
            end
            default: begin
                // walk the chain, clearing as we go
                c = cl;
                steps = 0;
                walking = 1'b1;
                while (walking && c >= 2 && c < fcct_pkg::END_OF_CHAIN) begin
                    if (c >= n) begin
                        st = fcct_pkg::ST_RANGE;
                        walking = 1'b0;
                    end else if (steps >= n) begin
                        st = fcct_pkg::ST_LIMIT;
                        walking = 1'b0;
                    end else begin
                        nx = fat_copy[c];
                        fat_copy[c] = 16'd0;
                        c = nx;
                        steps++;
                    end
                end
            end
        endcase
        o.cl     = rc;
        o.sector = cfg_data_start + ({16'd0, rc} - 32'd2) * {24'd0, cfg_spc};
        o.eoc    = (rc >= fcct_pkg::END_OF_CHAIN);
        o.st     = st;
        return o;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
        mismatches++;
    endtask

    task automatic queue_request(input fcct_pkg::t_action act, input logic [15:0] cl,
                                 input logic [15:0] val);
        t_request rq;
        rq.act = act;
        rq.cl  = cl;
        rq.val = val;
        requests_pending.push_back(rq);
        requests_made++;
    endtask

    function automatic logic [15:0] pick_cluster();
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return 16'(live_entries() + $urandom_range(0, 2) - 1);
            2: return 16'($urandom_range(0, 1));
            default: return 16'($urandom_range(0, window() + 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1: return 16'($urandom());
            2: return fcct_pkg::END_OF_CHAIN + 16'($urandom_range(0, 7));
            3: return 16'd0;
            default: return pick_cluster();
        endcase
    endfunction

    // a linked chain in the low table, then a walk that frees it from its head or another node
    task automatic queue_chain();
        logic [15:0] nodes [0:5];
        logic [15:0] tail;
        int unsigned k, i;
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) nodes[i] = 16'($urandom_range(2, window() - 1));
        if ($urandom_range(0, 2) == 0)
            for (i = 0; i < k; i++)
                queue_request(fcct_pkg::ACT_ALLOC, pick_cluster(), pick_value());
        for (i = 0; i + 1 < k; i++) queue_request(fcct_pkg::ACT_LINK, nodes[i], nodes[i+1]);
        case ($urandom_range(0, 4))
            0: tail = fcct_pkg::END_OF_CHAIN + 16'($urandom_range(0, 7));
            1: tail = 16'd0;
            2: tail = nodes[0];
            3: tail = 16'(live_entries() + $urandom_range(0, 40));
            default: tail = 16'($urandom());
        endcase
        queue_request(fcct_pkg::ACT_LINK, nodes[k-1], tail);
        if ($urandom_range(0, 1) == 1)
            queue_request(fcct_pkg::ACT_NEXT, nodes[0], pick_value());
        if ($urandom_range(0, 4) == 0)
            queue_request(fcct_pkg::ACT_FREE, nodes[$urandom_range(0, k - 1)], pick_value());
        else
            queue_request(fcct_pkg::ACT_FREE, nodes[0], pick_value());
    endtask

    // apb write with setup and access phases; the local register copy follows at the write edge
    task automatic write_reg(input fcct_pkg::t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            fcct_pkg::REG_ENTRIES:    cfg_entries = data[14:0];
            fcct_pkg::REG_DATA_START: cfg_data_start = data;
            fcct_pkg::REG_SPC:        cfg_spc = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // block is idle once every request went out and every word came back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (requests_pending.size() != 0 || s_axis_tvalid || outcomes_due.size() != 0);
    endtask

    // request side: one word per launch, then a drawn gap
    always @(negedge i_clk) begin : request_driver
        t_request rq;
        if (i_rst_n && (req_fire || !s_axis_tvalid)) begin
            if (req_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                req_wait <= req_wait - 1;
            end else if (requests_pending.size() > 0) begin
                rq = requests_pending.pop_front();
                s_axis_tuser  <= rq.act;
                s_axis_tdata  <= {rq.val, rq.cl};
                s_axis_tvalid <= 1'b1;
                req_wait <= gap_draw(calm_req);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side: after each word, hold tready low for a drawn stall
    always @(negedge i_clk) begin : result_responder
        int unsigned d;
        if (res_fire) begin
            d = gap_draw(calm_res);
            m_axis_tready <= (d == 0);
            res_hold <= d;
        end else if (res_hold > 0) begin
            m_axis_tready <= (res_hold == 1);
            res_hold <= res_hold - 1;
        end
    end

    // check returned words first, then predict the request taken at this edge
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        req_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        res_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcomes_due.size() == 0) begin
                    note_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
                end else begin
                    want = outcomes_due.pop_front();
                    if (m_axis_tdata[15:0] !== want.cl)
                        note_mismatch("result_cluster", {16'd0, m_axis_tdata[15:0]},
                                      {16'd0, want.cl});
                    if (m_axis_tdata[47:16] !== want.sector)
                        note_mismatch("first_sector", m_axis_tdata[47:16], want.sector);
                    if (m_axis_tuser[0] !== want.eoc)
                        note_mismatch("end_of_chain", {31'd0, m_axis_tuser[0]},
                                      {31'd0, want.eoc});
                    if (m_axis_tuser[2:1] !== want.st)
                        note_mismatch("status", {30'd0, m_axis_tuser[2:1]}, {30'd0, want.st});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                outcomes_due.push_back(apply_request(fcct_pkg::t_action'(s_axis_tuser),
                                                     s_axis_tdata[15:0], s_axis_tdata[31:16]));
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned p, count, made_before, i;
        for (i = 0; i < fcct_pkg::TABLE_ENTRIES; i++) fat_copy[i] = 16'd0;
        fat_copy[0] = fcct_pkg::ENTRY0_RESET;
        fat_copy[1] = fcct_pkg::ENTRY1_RESET;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: reserved entries, table edges, short chain, walks outside range
        queue_request(fcct_pkg::ACT_ALLOC, 16'd0, 16'd0);
        queue_request(fcct_pkg::ACT_NEXT, 16'd0, 16'd0);
        queue_request(fcct_pkg::ACT_NEXT, 16'd1, 16'hFFFF);
        queue_request(fcct_pkg::ACT_NEXT, 16'd16383, 16'd0);
        queue_request(fcct_pkg::ACT_NEXT, 16'd16384, 16'd0);
        queue_request(fcct_pkg::ACT_LINK, 16'd3, 16'd4);
        queue_request(fcct_pkg::ACT_LINK, 16'd4, 16'hFFFF);
        queue_request(fcct_pkg::ACT_FREE, 16'd3, 16'd0);
        queue_request(fcct_pkg::ACT_LINK, 16'hFFFF, 16'h1234);
        queue_request(fcct_pkg::ACT_FREE, 16'd0, 16'd0);
        queue_request(fcct_pkg::ACT_FREE, 16'hFFFF, 16'hFFFF);
        queue_request(fcct_pkg::ACT_FREE, 16'hFFF7, 16'd0);
        queue_request(fcct_pkg::ACT_LINK, 16'd0, 16'hABCD);
        queue_request(fcct_pkg::ACT_NEXT, 16'd0, 16'd0);
        queue_request(fcct_pkg::ACT_LINK, 16'd1, 16'hFFFF);
        wait_idle();

        // tiny table at extreme sector settings: full table, a looping chain
        write_reg(fcct_pkg::REG_ENTRIES, 32'd4);
        write_reg(fcct_pkg::REG_DATA_START, 32'hFFFF_FFFF);
        write_reg(fcct_pkg::REG_SPC, 32'd128);
        @(posedge i_clk);
        queue_request(fcct_pkg::ACT_ALLOC, 16'd0, 16'd0);
        queue_request(fcct_pkg::ACT_ALLOC, 16'hFFFF, 16'hFFFF);
        queue_request(fcct_pkg::ACT_LINK, 16'd2, 16'd3);
        queue_request(fcct_pkg::ACT_LINK, 16'd3, 16'd2);
        queue_request(fcct_pkg::ACT_FREE, 16'd2, 16'd0);
        queue_request(fcct_pkg::ACT_NEXT, 16'd3, 16'd0);
        queue_request(fcct_pkg::ACT_NEXT, 16'd4, 16'd0);
        wait_idle();

        // no entries at all: everything is outside the table
        write_reg(fcct_pkg::REG_ENTRIES, 32'd0);
        @(posedge i_clk);
        queue_request(fcct_pkg::ACT_ALLOC, 16'd0, 16'd0);
        queue_request(fcct_pkg::ACT_NEXT, 16'd0, 16'd0);
        queue_request(fcct_pkg::ACT_LINK, 16'd0, 16'hFFF8);
        queue_request(fcct_pkg::ACT_FREE, 16'd2, 16'd0);
        wait_idle();

        // random phases, each under its own register settings
        p = 0;
        while (requests_made < ITEMS_TOTAL) begin
            write_reg(fcct_pkg::REG_ENTRIES, entries_plan[p % 12]);
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 3))
                    0: write_reg(fcct_pkg::REG_DATA_START, 32'd0);
                    1: write_reg(fcct_pkg::REG_DATA_START, 32'hFFFF_FFFF);
                    2: write_reg(fcct_pkg::REG_DATA_START, fcct_pkg::DATA_START_RESET);
                    default: write_reg(fcct_pkg::REG_DATA_START, $urandom());
                endcase
            end
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 5))
                    0: write_reg(fcct_pkg::REG_SPC, 32'd1);
                    1: write_reg(fcct_pkg::REG_SPC, 32'd128);
                    2: write_reg(fcct_pkg::REG_SPC, 32'd255);
                    3: write_reg(fcct_pkg::REG_SPC, 32'd0);
                    default: write_reg(fcct_pkg::REG_SPC, $urandom_range(1, 128));
                endcase
            end
            @(posedge i_clk);
            calm_req = ($urandom_range(0, 3) == 0);
            calm_res = ($urandom_range(0, 3) == 0);
            count = (live_entries() < 16) ? 30 : 125;
            made_before = requests_made;
            while (requests_made < made_before + count) begin
                if (window() >= 4 && $urandom_range(0, 99) < 60)
                    queue_chain();
                else
                    queue_request(fcct_pkg::t_action'($urandom_range(0, 3)), pick_cluster(),
                                  pick_value());
            end
            wait_idle();
            p++;
        end

        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
